// ===== rtl/core/grc_pkg.sv =====
`timescale 1ns / 1ps

package grc_pkg;

    localparam int MAP_BITS   = 6;
    localparam int MAP_SIZE   = 1 << MAP_BITS;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_STEPS  = 2 * MAP_SIZE;
    localparam int STEP_BITS  = $clog2(MAX_STEPS);

    // shared unit operand widths
    localparam int DIV_W  = 42;
    localparam int MUL_AW = 42;
    localparam int MUL_BW = 24;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y  = 3'd5;

    localparam logic CMD_WRITE_CELL = 1'b0;
    localparam logic CMD_CAST       = 1'b1;

    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

endpackage

// ===== rtl/core/grc_ram.sv =====
`timescale 1ns / 1ps

module grc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/grc_div.sv =====
`timescale 1ns / 1ps

module grc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [grc_pkg::DIV_W-1:0]  num,
    input  logic [grc_pkg::DIV_W-1:0]  den,
    output logic                       done,
    output logic [grc_pkg::DIV_W-1:0]  quot
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   rem_sh;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DIV_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== rtl/core/grc_mul.sv =====
`timescale 1ns / 1ps

module grc_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [grc_pkg::MUL_AW-1:0]  a,
    input  logic [grc_pkg::MUL_BW-1:0]  b,
    output logic                        done,
    output logic [grc_pkg::MUL_PW-1:0]  prod
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(MUL_BW + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MUL_PW-1:0] a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MUL_PW-1:0] acc_reg;

    // shift and add, one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_BW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= MUL_PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[MUL_PW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/grid_ray_column_caster.sv =====
`timescale 1ns / 1ps

// grid ray column caster
// input channel (in_valid / in_ready) takes one word per command: command 0
// writes one cell of the 64 x 64 wall map (read-modify-write of a 64-bit map
// row), command 1 casts the ray of screen_column
// a cast gives exactly one result word on the output channel (out_valid /
// out_ready); a cell write gives none
// a cast runs on shift-add multiplies and restoring divides (a zero ray
// component skips its divide) and walks the grid step by step (map row
// read, then wall test); one cast is in flight at a time
// configuration (cfg_valid / cfg_ready) is always ready; write registers only
// while the block is idle
// the result sits in an output register: a new command is taken while it
// waits, and a finished cast holds until the receiver takes the old word
// reset: registers take their default view, all map cells read as open at
// once through per-row valid bits, no clearing pass
module grid_ray_column_caster (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [5:0]                        cell_col,
    input  logic [5:0]                        cell_row,
    input  logic                              cell_is_wall,
    input  logic [9:0]                        screen_column,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [9:0]                        out_column,
    output logic                              wall_hit,
    output logic                              hit_side,
    output logic [1:0]                        wall_face,
    output logic [5:0]                        hit_col,
    output logic [5:0]                        hit_row,
    output logic [23:0]                       perp_distance,
    output logic [8:0]                        draw_start,
    output logic [8:0]                        draw_end,
    output logic [5:0]                        tex_column,
    output logic [21:0]                       tex_row_start,
    output logic [21:0]                       tex_row_step
);
    import grc_pkg::*;

    // sequencer codes: K states kick a shared unit, W states wait for it
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MWR   = 5'd1;
    localparam logic [4:0] S_CXK   = 5'd2;
    localparam logic [4:0] S_CXW   = 5'd3;
    localparam logic [4:0] S_CYK   = 5'd4;
    localparam logic [4:0] S_CYW   = 5'd5;
    localparam logic [4:0] S_DXK   = 5'd6;
    localparam logic [4:0] S_DXW   = 5'd7;
    localparam logic [4:0] S_DYK   = 5'd8;
    localparam logic [4:0] S_DYW   = 5'd9;
    localparam logic [4:0] S_SXK   = 5'd10;
    localparam logic [4:0] S_SXW   = 5'd11;
    localparam logic [4:0] S_SYK   = 5'd12;
    localparam logic [4:0] S_SYW   = 5'd13;
    localparam logic [4:0] S_WSTEP = 5'd14;
    localparam logic [4:0] S_WCHK  = 5'd15;
    localparam logic [4:0] S_LHK   = 5'd16;
    localparam logic [4:0] S_LHW   = 5'd17;
    localparam logic [4:0] S_FRK   = 5'd18;
    localparam logic [4:0] S_FRW   = 5'd19;
    localparam logic [4:0] S_STK   = 5'd20;
    localparam logic [4:0] S_STW   = 5'd21;
    localparam logic [4:0] S_SSK   = 5'd22;
    localparam logic [4:0] S_SSW   = 5'd23;
    localparam logic [4:0] S_OUT   = 5'd24;

    localparam logic [DIV_W-1:0] NUM_DELTA  = DIV_W'(1) << (2 * FRAC_BITS);
    localparam logic [DIV_W-1:0] NUM_HEIGHT = DIV_W'(1) << (2 * FRAC_BITS + 9);
    localparam logic [DIV_W-1:0] NUM_TEX    = DIV_W'(1) << (2 * FRAC_BITS + 6);
    localparam logic [33:0]      DELTA_SAT  = 34'(1) << (2 * FRAC_BITS + 1);
    localparam logic [42:0]      HALF_ROWS  = 43'(1) << (FRAC_BITS + 8);
    localparam logic [40:0]      PERP_CAP   = '1;
    localparam logic [16:0]      ONE_Q      = 17'(1) << FRAC_BITS;

    logic [4:0] state_reg, state_next;

    // configuration
    logic [21:0]        player_x_reg, player_y_reg;
    logic signed [18:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    // cast datapath
    logic [9:0]         col_reg;
    logic [5:0]         row_reg, ccol_reg;
    logic               wall_reg;
    logic signed [17:0] cam_reg;
    logic signed [19:0] rdx_reg, rdy_reg;
    logic [33:0]        dx_reg, dy_reg;
    logic [41:0]        sx_reg, sy_reg;
    logic [6:0]         mx_reg, my_reg;
    logic               side_reg;
    logic [STEP_BITS-1:0] steps_reg;
    logic               hit_reg;
    logic [41:0]        perp_reg;
    logic [41:0]        lh_reg;
    logic [15:0]        frac_reg;
    logic [21:0]        step_reg;
    logic [21:0]        start_reg;
    logic               mul_sign_reg;
    logic [MAP_SIZE-1:0] row_valid_reg;

    // output word
    logic        out_valid_reg;
    logic [9:0]  o_col_reg;
    logic        o_hit_reg, o_side_reg;
    logic [1:0]  o_face_reg;
    logic [5:0]  o_hcol_reg, o_hrow_reg, o_tex_reg;
    logic [23:0] o_perp_reg;
    logic [8:0]  o_ds_reg, o_de_reg;
    logic [21:0] o_tstart_reg, o_tstep_reg;

    // shared units
    logic               mul_start, mul_done, div_start, div_done;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic [MUL_PW-1:0]  mul_prod;
    logic [DIV_W-1:0]   div_num, div_den, div_quot;

    // map memory
    logic                ram_we;
    logic [MAP_BITS-1:0] ram_addr;
    logic [MAP_SIZE-1:0] ram_wdata, ram_rdata, row_word;

    // combinational helpers
    logic               in_fire, out_free;
    logic [16:0]        cam_mag;
    logic [18:0]        plx_mag, ply_mag;
    logic [19:0]        rdx_mag, rdy_mag;
    logic signed [MUL_PW:0] prod_s, prod_sh;
    logic signed [19:0] ray_next;
    logic [16:0]        fx_run, fy_run;
    logic               walk_x;
    logic [6:0]         mx_step, my_step;
    logic [41:0]        perp_calc;
    logic [40:0]        pc;
    logic [41:0]        hs;
    logic [42:0]        span_hi, span_lo;
    logic [8:0]         ds, de;
    logic [42:0]        v_raw, v;
    logic               mirror;
    logic [5:0]         tex_raw, tex;
    logic [1:0]         face;
    logic [MUL_PW-FRAC_BITS-1:0] prod_q;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // magnitudes for the unsigned multiplier
    assign cam_mag = cam_reg[17] ? 17'(-cam_reg) : cam_reg[16:0];
    assign plx_mag = plane_x_reg[18] ? 19'(-plane_x_reg) : plane_x_reg;
    assign ply_mag = plane_y_reg[18] ? 19'(-plane_y_reg) : plane_y_reg;
    assign rdx_mag = rdx_reg[19] ? 20'(-rdx_reg) : rdx_reg;
    assign rdy_mag = rdy_reg[19] ? 20'(-rdy_reg) : rdy_reg;

    // signed product, arithmetic shift floors toward minus infinity
    assign prod_s  = mul_sign_reg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
    assign prod_sh = prod_s >>> FRAC_BITS;
    assign prod_q  = mul_prod[MUL_PW-1:FRAC_BITS];

    always_comb
    begin
        if (state_reg == S_CXW)
        begin
            ray_next = {dir_x_reg[18], dir_x_reg} + prod_sh[19:0];
        end
        else
        begin
            ray_next = {dir_y_reg[18], dir_y_reg} + prod_sh[19:0];
        end
    end

    // distance to the first grid line on each axis
    assign fx_run = rdx_reg[19] ? {1'b0, player_x_reg[15:0]} : 17'(ONE_Q - player_x_reg[15:0]);
    assign fy_run = rdy_reg[19] ? {1'b0, player_y_reg[15:0]} : 17'(ONE_Q - player_y_reg[15:0]);

    // dda step
    assign walk_x  = sx_reg < sy_reg;
    assign mx_step = rdx_reg[19] ? 7'(mx_reg - 7'd1) : 7'(mx_reg + 7'd1);
    assign my_step = rdy_reg[19] ? 7'(my_reg - 7'd1) : 7'(my_reg + 7'd1);

    assign perp_calc = side_reg ? 42'(sy_reg - dy_reg) : 42'(sx_reg - dx_reg);
    assign pc        = (perp_reg > 42'(PERP_CAP)) ? PERP_CAP : perp_reg[40:0];

    // vertical span of the slice
    assign hs      = {1'b0, lh_reg[41:1]};
    assign span_hi = HALF_ROWS + 43'(hs);
    assign span_lo = 43'(HALF_ROWS - 43'(hs));
    assign ds      = (43'(hs) >= HALF_ROWS) ? 9'd0 : span_lo[24:16];
    assign de      = (span_hi[42:16] >= 27'd512) ? 9'd511 : span_hi[24:16];
    assign v_raw   = {18'd0, ds, 16'd0} + 43'(hs);
    assign v       = (v_raw > HALF_ROWS) ? 43'(v_raw - HALF_ROWS) : 43'd0;

    // texture column and face
    assign tex_raw = frac_reg[15:10];
    assign mirror  = side_reg ? rdy_reg[19] : (!rdx_reg[19] && rdx_reg != '0);
    assign tex     = mirror ? 6'(6'd63 - tex_raw) : tex_raw;
    always_comb
    begin
        if (!side_reg)
        begin
            face = (!rdx_reg[19] && rdx_reg != '0) ? FACE_EAST : FACE_WEST;
        end
        else
        begin
            face = rdy_reg[19] ? FACE_NORTH : FACE_SOUTH;
        end
    end

    // unit operand selection
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = NUM_DELTA;
        div_den = '0;
        unique case (state_reg)
            S_CXK:
            begin
                mul_start = 1'b1;
                mul_a = MUL_AW'(plx_mag);
                mul_b = MUL_BW'(cam_mag);
            end
            S_CYK:
            begin
                mul_start = 1'b1;
                mul_a = MUL_AW'(ply_mag);
                mul_b = MUL_BW'(cam_mag);
            end
            S_DXK:
            begin
                div_start = (rdx_reg != '0);
                div_den = DIV_W'(rdx_mag);
            end
            S_DYK:
            begin
                div_start = (rdy_reg != '0);
                div_den = DIV_W'(rdy_mag);
            end
            S_SXK:
            begin
                mul_start = 1'b1;
                mul_a = MUL_AW'(dx_reg);
                mul_b = MUL_BW'(fx_run);
            end
            S_SYK:
            begin
                mul_start = 1'b1;
                mul_a = MUL_AW'(dy_reg);
                mul_b = MUL_BW'(fy_run);
            end
            S_LHK:
            begin
                div_start = 1'b1;
                div_num = NUM_HEIGHT;
                div_den = (perp_reg == '0) ? DIV_W'(1) : perp_reg;
            end
            S_FRK:
            begin
                mul_start = 1'b1;
                mul_a = MUL_AW'(pc);
                mul_b = side_reg ? MUL_BW'(rdx_mag) : MUL_BW'(rdy_mag);
            end
            S_STK:
            begin
                div_start = (lh_reg != '0);
                div_num = NUM_TEX;
                div_den = lh_reg;
            end
            S_SSK:
            begin
                mul_start = 1'b1;
                mul_a = MUL_AW'(v);
                mul_b = MUL_BW'(step_reg);
            end
            default:
            begin
            end
        endcase
    end

    grc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // map rows: the read address follows the sequencer, writes merge one bit
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            ram_addr = cell_row;
        end
        else if (state_reg == S_WSTEP)
        begin
            ram_addr = walk_x ? my_reg[MAP_BITS-1:0] : my_step[MAP_BITS-1:0];
        end
        else if (state_reg == S_WCHK)
        begin
            // row fetched in the step cycle, its valid bit picked here
            ram_addr = my_reg[MAP_BITS-1:0];
        end
        else
        begin
            ram_addr = row_reg;
        end
    end

    assign row_word = row_valid_reg[ram_addr] ? ram_rdata : '0;
    assign ram_we   = (state_reg == S_MWR);

    always_comb
    begin
        ram_wdata = row_word;
        ram_wdata[ccol_reg] = wall_reg;
    end

    grc_ram #(
        .WIDTH (MAP_SIZE),
        .DEPTH (MAP_SIZE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (command == CMD_CAST) ? S_CXK : S_MWR;
                end
            end
            S_MWR:   state_next = S_IDLE;
            S_CXK:   state_next = S_CXW;
            S_CXW:   state_next = mul_done ? S_CYK : S_CXW;
            S_CYK:   state_next = S_CYW;
            S_CYW:   state_next = mul_done ? S_DXK : S_CYW;
            S_DXK:   state_next = (rdx_reg != '0) ? S_DXW : S_DYK;
            S_DXW:   state_next = div_done ? S_DYK : S_DXW;
            S_DYK:   state_next = (rdy_reg != '0) ? S_DYW : S_SXK;
            S_DYW:   state_next = div_done ? S_SXK : S_DYW;
            S_SXK:   state_next = S_SXW;
            S_SXW:   state_next = mul_done ? S_SYK : S_SXW;
            S_SYK:   state_next = S_SYW;
            S_SYW:   state_next = mul_done ? S_WSTEP : S_SYW;
            S_WSTEP:
            begin
                if ((walk_x && mx_step[MAP_BITS]) || (!walk_x && my_step[MAP_BITS]))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (row_word[mx_reg[MAP_BITS-1:0]])
                begin
                    state_next = S_LHK;
                end
                else if (steps_reg == STEP_BITS'(MAX_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WSTEP;
                end
            end
            S_LHK:   state_next = S_LHW;
            S_LHW:   state_next = div_done ? S_FRK : S_LHW;
            S_FRK:   state_next = S_FRW;
            S_FRW:   state_next = mul_done ? S_STK : S_FRW;
            S_STK:   state_next = (lh_reg != '0) ? S_STW : S_SSK;
            S_STW:   state_next = div_done ? S_SSK : S_STW;
            S_SSK:   state_next = S_SSW;
            S_SSW:   state_next = mul_done ? S_OUT : S_SSW;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            player_x_reg  <= 22'd2129920;
            player_y_reg  <= 22'd2129920;
            dir_x_reg     <= 19'sd0;
            dir_y_reg     <= -19'sd65536;
            plane_x_reg   <= 19'sd43254;
            plane_y_reg   <= 19'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MWR)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PLAYER_X: player_x_reg <= cfg_data;
                    REG_PLAYER_Y: player_y_reg <= cfg_data;
                    REG_DIR_X:    dir_x_reg    <= cfg_data[18:0];
                    REG_DIR_Y:    dir_y_reg    <= cfg_data[18:0];
                    REG_PLANE_X:  plane_x_reg  <= cfg_data[18:0];
                    REG_PLANE_Y:  plane_y_reg  <= cfg_data[18:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    col_reg  <= screen_column;
                    row_reg  <= cell_row;
                    ccol_reg <= cell_col;
                    wall_reg <= cell_is_wall;
                    if (screen_column == 10'd1023)
                    begin
                        cam_reg <= 18'sd65536;
                    end
                    else
                    begin
                        cam_reg <= $signed({1'b0, screen_column, 7'd0}) - 18'sd65536;
                    end
                end
            end
            S_CXK:   mul_sign_reg <= plane_x_reg[18] ^ cam_reg[17];
            S_CXW:   rdx_reg <= ray_next;
            S_CYK:   mul_sign_reg <= plane_y_reg[18] ^ cam_reg[17];
            S_CYW:   rdy_reg <= ray_next;
            S_DXK:   dx_reg <= DELTA_SAT;
            S_DXW:   dx_reg <= 34'(div_quot);
            S_DYK:   dy_reg <= DELTA_SAT;
            S_DYW:   dy_reg <= 34'(div_quot);
            S_SXK:   mul_sign_reg <= 1'b0;
            S_SXW:   sx_reg <= 42'(prod_q);
            S_SYW:
            begin
                sy_reg    <= 42'(prod_q);
                mx_reg    <= {1'b0, player_x_reg[21:16]};
                my_reg    <= {1'b0, player_y_reg[21:16]};
                steps_reg <= '0;
                hit_reg   <= 1'b0;
                side_reg  <= 1'b0;
            end
            S_WSTEP:
            begin
                if (walk_x)
                begin
                    sx_reg   <= 42'(sx_reg + 42'(dx_reg));
                    mx_reg   <= mx_step;
                    side_reg <= 1'b0;
                end
                else
                begin
                    sy_reg   <= 42'(sy_reg + 42'(dy_reg));
                    my_reg   <= my_step;
                    side_reg <= 1'b1;
                end
            end
            S_WCHK:
            begin
                steps_reg <= STEP_BITS'(steps_reg + 1'b1);
                if (row_word[mx_reg[MAP_BITS-1:0]])
                begin
                    hit_reg  <= 1'b1;
                    perp_reg <= perp_calc;
                end
            end
            S_LHW:   lh_reg <= div_quot;
            S_FRK:   mul_sign_reg <= side_reg ? rdx_reg[19] : rdy_reg[19];
            S_FRW:
            begin
                frac_reg <= 16'((side_reg ? player_x_reg[15:0] : player_y_reg[15:0])
                                + prod_sh[15:0]);
            end
            S_STK:   step_reg <= '1;
            S_STW:   step_reg <= (div_quot > DIV_W'(22'h3FFFFF)) ? 22'h3FFFFF : div_quot[21:0];
            S_SSK:   mul_sign_reg <= 1'b0;
            S_SSW:
            begin
                start_reg <= (prod_q > (MUL_PW-FRAC_BITS)'(22'h3FFFFF))
                             ? 22'h3FFFFF : prod_q[21:0];
            end
            default:
            begin
            end
        endcase
    end

    // output word, all fields but the column zero when no wall was met
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            o_col_reg <= col_reg;
            o_hit_reg <= hit_reg;
            if (hit_reg)
            begin
                o_side_reg   <= side_reg;
                o_face_reg   <= face;
                o_hcol_reg   <= mx_reg[MAP_BITS-1:0];
                o_hrow_reg   <= my_reg[MAP_BITS-1:0];
                o_perp_reg   <= (perp_reg > 42'hFFFFFF) ? 24'hFFFFFF : perp_reg[23:0];
                o_ds_reg     <= ds;
                o_de_reg     <= de;
                o_tex_reg    <= tex;
                o_tstart_reg <= start_reg;
                o_tstep_reg  <= step_reg;
            end
            else
            begin
                o_side_reg   <= 1'b0;
                o_face_reg   <= FACE_EAST;
                o_hcol_reg   <= '0;
                o_hrow_reg   <= '0;
                o_perp_reg   <= '0;
                o_ds_reg     <= '0;
                o_de_reg     <= '0;
                o_tex_reg    <= '0;
                o_tstart_reg <= '0;
                o_tstep_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_column    = o_col_reg;
    assign wall_hit      = o_hit_reg;
    assign hit_side      = o_side_reg;
    assign wall_face     = o_face_reg;
    assign hit_col       = o_hcol_reg;
    assign hit_row       = o_hrow_reg;
    assign perp_distance = o_perp_reg;
    assign draw_start    = o_ds_reg;
    assign draw_end      = o_de_reg;
    assign tex_column    = o_tex_reg;
    assign tex_row_start = o_tstart_reg;
    assign tex_row_step  = o_tstep_reg;

endmodule
